// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the keyed block transposition RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define KBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define KBT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kbt_pkg.sv =====
// Package: shared types and constants of the keyed block transposition
`default_nettype none
package kbt_pkg;

    localparam int MAX_BLOCK = 8;
    localparam int KEY_W     = 3;
    localparam int CFG_W     = 24;

    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] REG_KEY_WORD     = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

    localparam logic [3:0]  BLOCK_SIZE_RST = 4'd8;
    localparam logic [23:0] KEY_WORD_RST   = 24'hFAC688;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] PAD_LOWER  = 8'h7A;  // 'z'
    localparam logic [7:0] PAD_UPPER  = 8'h5A;  // 'Z'
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef struct packed {
        logic take;     // accept the input beat
        logic step;     // load next permuted char into output register
    } kbt_cmd_t;

    typedef struct packed {
        logic emit_req; // current input beat closes a block
        logic last_idx; // emit index is at the final position
        logic out_room; // output register free this cycle
    } kbt_status_t;

endpackage
`default_nettype wire

// ===== rtl/kbt_datapath.sv =====
// Datapath: config registers, block buffer, fill count, permutation and output register
`default_nettype none
`include "assert_macros.svh"
module kbt_datapath
    import kbt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic [7:0]        in_char,
    input  wire logic              in_end,
    input  wire kbt_cmd_t          cmd,
    output kbt_status_t            st,
    output logic                   out_valid,
    output logic [7:0]             out_char,
    output logic                   out_blk_last,
    output logic                   out_msg_last,
    input  wire logic              out_ready
);

    logic [3:0]           bsize_reg;
    logic [CFG_W-1:0]     key_reg;
    logic                 dec_reg;
    logic [7:0]           buf_mem [MAX_BLOCK];
    logic [3:0]           fill_reg, fill_next;
    logic                 end_reg;
    logic [2:0]           idx_reg, idx_next;
    logic                 oval_reg, oval_next;
    logic [7:0]           ochar_reg;
    logic                 oblk_reg;
    logic                 omsg_reg;

    logic [3:0]           size;
    logic [3:0]           pos;
    logic                 is_space;
    logic [KEY_W-1:0]     key_f [MAX_BLOCK];
    logic [2:0]           src;
    logic [7:0]           src_char;
    logic [7:0]           conv_char;

    function automatic logic [7:0] convert(input logic [7:0] ch, input logic dec);
        logic [7:0] r;
        r = ch;
        if (dec && ch >= 8'h41 && ch <= 8'h5A)
        begin
            r = ch + CASE_DELTA;
        end
        else if (!dec && ch >= 8'h61 && ch <= 8'h7A)
        begin
            r = ch - CASE_DELTA;
        end
        return r;
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg <= BLOCK_SIZE_RST;
            key_reg   <= KEY_WORD_RST;
            dec_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BLOCK_SIZE:   bsize_reg <= cfg_wdata[3:0];
                REG_KEY_WORD:     key_reg   <= cfg_wdata;
                REG_DECRYPT_MODE: dec_reg   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (bsize_reg == 4'd0)
            size = 4'd1;
        else if (bsize_reg > 4'(MAX_BLOCK))
            size = 4'(MAX_BLOCK);
        else
            size = bsize_reg;
    end

    assign is_space = (in_char == CHAR_SPACE);
    assign pos      = (fill_reg >= size) ? (size - 4'd1) : fill_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_BLOCK; i++)
            key_f[i] = key_reg[KEY_W*i +: KEY_W];
    end

    // source position of the current output slot
    always_comb
    begin
        src = 3'd0;
        if (dec_reg)
        begin
            for (int l = 0; l < MAX_BLOCK; l++)
                if (4'(l) < size && key_f[l] == idx_reg)
                    src = 3'(l);
        end
        else if ({1'b0, key_f[idx_reg]} < size)
        begin
            src = key_f[idx_reg];
        end
    end

    // slots at or beyond the fill count hold the pad
    assign src_char  = ({1'b0, src} >= fill_reg) ? (dec_reg ? PAD_UPPER : PAD_LOWER)
                                                 : buf_mem[src];
    assign conv_char = convert(src_char, dec_reg);

    assign st.emit_req = (!is_space && (pos + 4'd1 >= size))
                       || (in_end && (!is_space || fill_reg != 4'd0));
    assign st.last_idx = ({1'b0, idx_reg} == size - 4'd1);
    assign st.out_room = !oval_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.take && !is_space)
            buf_mem[pos[2:0]] <= in_char;
    end

    always_comb
    begin
        fill_next = fill_reg;
        idx_next  = idx_reg;
        oval_next = oval_reg && !out_ready;
        if (cmd.take && !is_space)
            fill_next = pos + 4'd1;
        if (cmd.step)
        begin
            oval_next = 1'b1;
            if (st.last_idx)
            begin
                idx_next  = 3'd0;
                fill_next = 4'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 4'd0;
            idx_reg  <= 3'd0;
            oval_reg <= 1'b0;
            end_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            oval_reg <= oval_next;
            if (cmd.take)
                end_reg <= in_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            ochar_reg <= conv_char;
            oblk_reg  <= st.last_idx;
            omsg_reg  <= st.last_idx && end_reg;
        end
    end

    assign out_valid    = oval_reg;
    assign out_char     = ochar_reg;
    assign out_blk_last = oblk_reg;
    assign out_msg_last = omsg_reg;

    `KBT_ASSERT(a_fill_range, fill_reg <= 4'(MAX_BLOCK), "fill count beyond block")
    `KBT_ASSERT(a_msg_in_blk, oval_reg && omsg_reg |-> oblk_reg, "msg_last without block_last")
    `KBT_ASSERT(a_clear_after_blk, cmd.step && st.last_idx |=> fill_reg == 4'd0 && idx_reg == 3'd0,
        "block state not cleared after emit")

endmodule
`default_nettype wire

// ===== rtl/kbt_ctrl.sv =====
// Controller: sequences input acceptance and per-character block emission
`default_nettype none
`include "assert_macros.svh"
module kbt_ctrl
    import kbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire kbt_status_t st,
    output kbt_cmd_t         cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.take   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && st.emit_req)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.step = st.out_room;
                if (st.out_room && st.last_idx)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `KBT_ASSERT(a_no_take_and_step, !(cmd.take && cmd.step), "take and step in one cycle")
    `KBT_ASSERT(a_blk_starts_emit, cmd.take && st.emit_req |=> state_reg == ST_EMIT,
        "closed block not emitted")

endmodule
`default_nettype wire

// ===== rtl/keyed_block_transposition.sv =====
// Top level: keyed block transposition over a beat stream
//
// Input beats carry one message byte in s_tdata[7:0]; s_tlast marks the final
// byte of a message. Spaces are dropped, other bytes fill a block of
// block_size characters. A full block, or a partial one closed by s_tlast
// (padded with 'z' in plaintext form), is emitted permuted by the key.
// Output beats carry one character in m_tdata[7:0], m_tuser flags the last
// character of a block and m_tlast the last one of a message.
// Config: cfg_we writes cfg_wdata to register cfg_addr (0 block_size,
// 1 key_word, 2 decrypt_mode). The user must write only while no block is
// in flight; the block itself does not enforce it. Timing: an input beat
// that does not close a block leaves the controller idle and ready for the
// next beat. A beat that closes a block of N characters moves it to emit,
// where each step loads the next character into the single output register,
// one character per cycle while the receiver takes them. No input is taken
// during emit; the next beat is taken as soon as the last character sits in
// the output register. A stalled receiver holds m_tdata and pauses emission.
// Reset: config returns to its defaults and the block is empty.
`default_nettype none
module keyed_block_transposition
    import kbt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] char_in
    input  wire logic              s_tlast,   // msg_end
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [7:0] char_out
    output logic                   m_tuser,   // [0] block_last
    output logic                   m_tlast    // msg_last
);

    kbt_cmd_t    cmd;
    kbt_status_t st;

    kbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    kbt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_char      (s_tdata),
        .in_end       (s_tlast),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (m_tvalid),
        .out_char     (m_tdata),
        .out_blk_last (m_tuser),
        .out_msg_last (m_tlast),
        .out_ready    (m_tready)
    );

endmodule
`default_nettype wire

// ===== tb/kbt_checker.sv =====
// Checker: predicts the permuted characters of the keyed block transposition and compares beats
module kbt_checker
    import kbt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,
    input  logic             m_tuser,
    input  logic             m_tlast,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       blk_last;
        logic       msg_last;
    } cipher_beat_t;

    cipher_beat_t exp_cipher_q[$];
    cipher_beat_t got_beat;

    logic [3:0]  size_reg;
    logic [23:0] key_reg;
    logic        dec_reg;
    logic [7:0]  blk_buf [MAX_BLOCK];
    int          fill;
    int          err_total;

    function automatic int active_size();
        int n;
        n = int'(size_reg);
        if (n == 0)
            n = 1;
        if (n > MAX_BLOCK)
            n = MAX_BLOCK;
        return n;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] ch, input logic dec);
        if (dec)
        begin
            if (ch >= "A" && ch <= "Z")
                return ch + CASE_DELTA;
        end
        else if (ch >= "a" && ch <= "z")
            return ch - CASE_DELTA;
        return ch;
    endfunction

    task automatic push_block(input int n, input logic end_flag);
        int j;
        int l;
        int src;
        cipher_beat_t b;
        for (j = 0; j < n; j++)
        begin
            src = 0;
            if (dec_reg)
            begin
                for (l = 0; l < n; l++)
                    if (int'(key_reg[3*l +: 3]) == j)
                        src = l;
            end
            else
            begin
                src = int'(key_reg[3*j +: 3]);
                if (src >= n)
                    src = 0;
            end
            b.ch       = fold_case(blk_buf[src], dec_reg);
            b.blk_last = (j == n - 1);
            b.msg_last = end_flag && (j == n - 1);
            exp_cipher_q.push_back(b);
        end
        fill = 0;
    endtask

    task automatic predict_transpose(input logic [7:0] ch, input logic end_flag);
        int n;
        int pos;
        int p;
        n = active_size();
        if (ch != CHAR_SPACE)
        begin
            pos = fill;
            if (pos >= n)
                pos = n - 1;
            blk_buf[pos] = ch;
            fill = pos + 1;
            if (fill >= n)
            begin
                push_block(n, end_flag);
                return;
            end
        end
        if (end_flag && fill > 0)
        begin
            for (p = fill; p < n; p++)
                blk_buf[p] = dec_reg ? PAD_UPPER : PAD_LOWER;
            push_block(n, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = BLOCK_SIZE_RST;
            key_reg  = KEY_WORD_RST;
            dec_reg  = 1'b0;
            fill     = 0;
            err_total = 0;
            exp_cipher_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_cipher_q.size() == 0)
                begin
                    $error("unexpected output beat: char_out %h block_last %b msg_last %b",
                           m_tdata, m_tuser, m_tlast);
                    err_total++;
                end
                else
                begin
                    got_beat = exp_cipher_q.pop_front();
                    if (m_tdata !== got_beat.ch)
                    begin
                        $error("char_out: expected %h, got %h", got_beat.ch, m_tdata);
                        err_total++;
                    end
                    if (m_tuser !== got_beat.blk_last)
                    begin
                        $error("block_last: expected %b, got %b", got_beat.blk_last, m_tuser);
                        err_total++;
                    end
                    if (m_tlast !== got_beat.msg_last)
                    begin
                        $error("msg_last: expected %b, got %b", got_beat.msg_last, m_tlast);
                        err_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_transpose(s_tdata, s_tlast);
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BLOCK_SIZE:   size_reg = cfg_wdata[3:0];
                    REG_KEY_WORD:     key_reg  = cfg_wdata[23:0];
                    REG_DECRYPT_MODE: dec_reg  = cfg_wdata[0];
                    default: ;
                endcase
            end
            fail_count <= err_total;
            pending    <= exp_cipher_q.size();
        end
    end

endmodule

// ===== tb/tb_keyed_block_transposition.sv =====
// Testbench top: stimulus, stalls, watchdog and verdict for the keyed block transposition
module tb_keyed_block_transposition;
    import kbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_addr  = REG_BLOCK_SIZE;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   rx_hold     = 0;
    int   rx_gap;
    logic rx_calm     = 1'b0;
    logic tx_calm     = 1'b0;

    always #10 clk = ~clk;

    keyed_block_transposition u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    kbt_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 15)
        begin
            rx_gap   = stall_len();
            m_tready <= 1'b0;
            rx_hold  <= rx_gap - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** keyed_block_transposition: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] ch, input logic last);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (!tx_calm && $urandom_range(0, 99) < 30)
        begin
            g = stall_len();
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // stop sending and wait until every predicted beat has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] bs, input logic [23:0] key, input logic dec);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_BLOCK_SIZE;
        cfg_wdata <= CFG_W'(bs);
        @(posedge clk);
        cfg_addr  <= REG_KEY_WORD;
        cfg_wdata <= CFG_W'(key);
        @(posedge clk);
        cfg_addr  <= REG_DECRYPT_MODE;
        cfg_wdata <= CFG_W'(dec);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // permutation of 0..n-1 in the live fields, random keys above
    function automatic logic [23:0] perm_key(input int n);
        int          p [MAX_BLOCK];
        int          i;
        int          k;
        int          t;
        logic [23:0] key;
        for (i = 0; i < MAX_BLOCK; i++)
            p[i] = (i < n) ? i : $urandom_range(0, MAX_BLOCK - 1);
        for (i = n - 1; i > 0; i--)
        begin
            k    = $urandom_range(0, i);
            t    = p[i];
            p[i] = p[k];
            p[k] = t;
        end
        key = '0;
        for (i = 0; i < MAX_BLOCK; i++)
            key[3*i +: 3] = p[i][2:0];
        return key;
    endfunction

    function automatic logic [7:0] rand_char(input logic dec);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CHAR_SPACE;
        if (r < 60)
            return (dec ? "A" : "a") + 8'($urandom_range(0, 25));
        if (r < 78)
            return (dec ? "a" : "A") + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_message(input int len, input logic dec);
        int i;
        for (i = 0; i < len; i++)
            send_beat(rand_char(dec), i == len - 1);
    endtask

    initial
    begin
        int          ph;
        int          sent;
        int          len;
        int          i;
        logic [3:0]  bs;
        logic [23:0] key;
        logic        dec;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: full block with a dropped space, then a padded partial block
        send_beat("a", 1'b0);
        send_beat("b", 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat("c", 1'b0);
        send_beat("d", 1'b0);
        send_beat("e", 1'b0);
        send_beat("f", 1'b0);
        send_beat("g", 1'b0);
        send_beat("z", 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);

        // decrypt, duplicate and missing keys, space on the final byte, empty flush
        set_config(4'd3, 24'hFFFE12, 1'b1);
        send_beat("A", 1'b0);
        send_beat("Z", 1'b0);
        send_beat(CHAR_SPACE, 1'b1);
        send_beat("M", 1'b1);
        send_beat(CHAR_SPACE, 1'b1);

        // size zero acts as one, keys beyond the block
        set_config(4'd0, 24'hFFFFFF, 1'b0);
        send_beat("q", 1'b0);
        send_beat("Q", 1'b1);

        // block shrunk while filling
        set_config(4'd8, KEY_WORD_RST, 1'b0);
        send_beat("a", 1'b0);
        send_beat("b", 1'b0);
        send_beat("c", 1'b0);
        set_config(4'd2, 24'h000001, 1'b1);
        send_beat("D", 1'b0);

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       begin bs = 4'd8;  dec = 1'b0; end
                1:       begin bs = 4'd1;  dec = 1'b1; end
                2:       begin bs = 4'd15; dec = 1'b0; end
                3:       begin bs = 4'd9;  dec = 1'b1; end
                default: begin bs = 4'($urandom_range(0, 15)); dec = 1'($urandom_range(0, 1)); end
            endcase
            if ($urandom_range(0, 1) == 1)
                key = perm_key((bs == 0) ? 1 : (bs > MAX_BLOCK) ? MAX_BLOCK : int'(bs));
            else
                key = 24'($urandom());
            set_config(bs, key, dec);
            rx_calm <= (ph == 0);
            tx_calm <= (ph == 0);
            sent = 0;
            while (sent < 8)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    len = $urandom_range(1, 3);
                    for (i = 0; i < len; i++)
                        send_beat(CHAR_SPACE, i == len - 1);
                end
                else
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                      : $urandom_range(1, 12);
                    send_message(len, dec);
                end
                sent += len;
                if (ph == 4 && sent >= 7 && sent - len < 7)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** keyed_block_transposition: PASSED **");
        else
            $display("** keyed_block_transposition: FAILED **");
        $finish;
    end

endmodule

// ===== keyed_block_transposition.f =====
+incdir+rtl
rtl/kbt_pkg.sv
rtl/kbt_datapath.sv
rtl/kbt_ctrl.sv
rtl/keyed_block_transposition.sv
tb/kbt_checker.sv
tb/tb_keyed_block_transposition.sv
